>>> sv/apic_pkg.sv
// Package for the adaptive poll interval controller.
// Holds widths, reset values, register indexes and the mode type.
// No dependencies.
package apic_pkg;

  localparam int INTERVAL_BITS = 20;
  localparam int QUIET_BITS    = 24;
  localparam int OUT_BITS      = 20;
  localparam int GRACE_BITS    = 22;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 22;

  typedef logic [INTERVAL_BITS-1:0] interval_t;
  typedef logic [QUIET_BITS-1:0]    quiet_t;
  typedef logic [GRACE_BITS-1:0]    grace_t;
  typedef logic [OUT_BITS-1:0]      out_iv_t;
  typedef logic [CFG_IDX_BITS-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_BITS-1:0] cfg_data_t;

  typedef enum logic [1:0] {
    MODE_IDLE   = 2'd0,
    MODE_ACTIVE = 2'd1,
    MODE_BURST  = 2'd2,
    MODE_RETURN = 2'd3
  } mode_t;

  localparam cfg_idx_t REG_IDLE_INTERVAL   = 3'd0;
  localparam cfg_idx_t REG_ACTIVE_INTERVAL = 3'd1;
  localparam cfg_idx_t REG_BURST_INTERVAL  = 3'd2;
  localparam cfg_idx_t REG_DESCEND_STEP    = 3'd3;
  localparam cfg_idx_t REG_ASCEND_STEP     = 3'd4;
  localparam cfg_idx_t REG_ACTIVE_GRACE    = 3'd5;
  localparam cfg_idx_t REG_BURST_GRACE     = 3'd6;
  localparam cfg_idx_t REG_FIXED_MODE      = 3'd7;

  localparam logic [19:0] RST_IDLE_INTERVAL   = 20'd100000;
  localparam logic [19:0] RST_ACTIVE_INTERVAL = 20'd30000;
  localparam logic [19:0] RST_BURST_INTERVAL  = 20'd10000;
  localparam logic [19:0] RST_DESCEND_STEP    = 20'd600;
  localparam logic [19:0] RST_ASCEND_STEP     = 20'd1200;
  localparam grace_t      RST_ACTIVE_GRACE    = 22'd500000;
  localparam grace_t      RST_BURST_GRACE     = 22'd1500000;

endpackage

>>> sv/adaptive_poll_interval_controller_top.sv
// Adaptive poll interval controller, top level.
// One poll tick in, one interval and mode beat out. Depends on apic_pkg.
//
// A tick is taken in every unstalled cycle; its result is registered in the
// output register, or in the skid register if that one is full. Outside fixed
// mode the mode, interval and quiet time registers update at the accepting
// edge by one compare/add/subtract pass, so the rate is one tick per clock
// while unstalled. These two registers form the output stage; in_stall rises
// once both hold beats. A config write sets the mode to idle, clears quiet time.
module adaptive_poll_interval_controller_top (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   activity,
  output logic                   out_valid,
  input  logic                   out_stall,
  output apic_pkg::out_iv_t      interval_us,
  output logic [1:0]             poll_mode,
  input  logic                   cfg_we,
  input  apic_pkg::cfg_idx_t     cfg_index,
  input  apic_pkg::cfg_data_t    cfg_data
);
  import apic_pkg::*;

  // configuration
  interval_t idle_interval, active_interval, burst_interval;
  interval_t descend_step, ascend_step;
  grace_t    active_grace, burst_grace;
  logic      fixed_mode;
  interval_t idle_interval_next, burst_interval_next;
  logic      fixed_mode_next;

  // state
  mode_t     mode_state, mode_state_next;
  interval_t current_interval, current_interval_next;
  quiet_t    quiet_time, quiet_time_next;

  // output stage
  out_iv_t   res_interval, skid_interval;
  mode_t     res_mode, skid_mode;
  logic      skid_valid;
  logic      in_fire, out_fire;

  // step datapath
  logic [INTERVAL_BITS:0] quiet_sum_ext;
  logic [QUIET_BITS:0]    quiet_sum;
  quiet_t                 quiet_acc;
  logic                   active_grace_hit, burst_grace_hit;
  interval_t              desc_val;
  logic                   desc_stays;
  logic [INTERVAL_BITS:0] asc_sum;
  logic                   asc_stays;
  interval_t              step_interval;
  out_iv_t                beat_interval;
  mode_t                  beat_mode;

  assign in_fire  = in_valid && !in_stall;
  assign out_fire = out_valid && !out_stall;
  assign in_stall = skid_valid;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      idle_interval   <= RST_IDLE_INTERVAL;
      active_interval <= RST_ACTIVE_INTERVAL;
      burst_interval  <= RST_BURST_INTERVAL;
      descend_step    <= RST_DESCEND_STEP;
      ascend_step     <= RST_ASCEND_STEP;
      active_grace    <= RST_ACTIVE_GRACE;
      burst_grace     <= RST_BURST_GRACE;
      fixed_mode      <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_IDLE_INTERVAL:   idle_interval   <= cfg_data[INTERVAL_BITS-1:0];
        REG_ACTIVE_INTERVAL: active_interval <= cfg_data[INTERVAL_BITS-1:0];
        REG_BURST_INTERVAL:  burst_interval  <= cfg_data[INTERVAL_BITS-1:0];
        REG_DESCEND_STEP:    descend_step    <= cfg_data[INTERVAL_BITS-1:0];
        REG_ASCEND_STEP:     ascend_step     <= cfg_data[INTERVAL_BITS-1:0];
        REG_ACTIVE_GRACE:    active_grace    <= cfg_data[GRACE_BITS-1:0];
        REG_BURST_GRACE:     burst_grace     <= cfg_data[GRACE_BITS-1:0];
        REG_FIXED_MODE:      fixed_mode      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // values seen by the reinit after a write
  always_comb begin
    idle_interval_next  = idle_interval;
    burst_interval_next = burst_interval;
    fixed_mode_next     = fixed_mode;
    if (cfg_index == REG_IDLE_INTERVAL)  idle_interval_next  = cfg_data[INTERVAL_BITS-1:0];
    if (cfg_index == REG_BURST_INTERVAL) burst_interval_next = cfg_data[INTERVAL_BITS-1:0];
    if (cfg_index == REG_FIXED_MODE)     fixed_mode_next     = cfg_data[0];
  end

  // saturating quiet time, grace hits and step compares
  always_comb begin
    quiet_sum_ext = '0;
    quiet_sum     = {1'b0, quiet_time} + (QUIET_BITS+1)'(current_interval);
    quiet_acc     = quiet_sum[QUIET_BITS] ? {QUIET_BITS{1'b1}} : quiet_sum[QUIET_BITS-1:0];
    quiet_sum_ext = {1'b0, current_interval};
    active_grace_hit = quiet_acc >= QUIET_BITS'(active_grace);
    burst_grace_hit  = quiet_acc >= QUIET_BITS'(burst_grace);
    desc_val   = current_interval - descend_step;
    desc_stays = (current_interval > burst_interval) && (current_interval > descend_step)
                 && (desc_val > burst_interval);
    asc_sum    = quiet_sum_ext + {1'b0, ascend_step};
    asc_stays  = (current_interval < idle_interval)
                 && (asc_sum < {1'b0, idle_interval});
  end

  // next state
  always_comb begin
    mode_state_next = mode_state;
    case (mode_state)
      MODE_IDLE:   if (activity) mode_state_next = MODE_ACTIVE;
      MODE_ACTIVE: begin
        if (activity) begin
          if (!desc_stays) mode_state_next = MODE_BURST;
        end else if (active_grace_hit) begin
          mode_state_next = MODE_RETURN;
        end
      end
      MODE_BURST:  if (!activity && burst_grace_hit) mode_state_next = MODE_RETURN;
      MODE_RETURN: begin
        if (activity)        mode_state_next = MODE_ACTIVE;
        else if (!asc_stays) mode_state_next = MODE_IDLE;
      end
      default: mode_state_next = MODE_IDLE;
    endcase
  end

  // interval datapath and beat contents
  always_comb begin
    step_interval = current_interval;
    case (mode_state)
      MODE_IDLE:   if (activity) step_interval = active_interval;
      MODE_ACTIVE: begin
        if (activity) step_interval = desc_stays ? desc_val : burst_interval;
      end
      MODE_BURST:  step_interval = current_interval;
      MODE_RETURN: begin
        if (activity) begin
          step_interval = (current_interval > active_interval) ? active_interval
                                                               : current_interval;
        end else begin
          step_interval = asc_stays ? asc_sum[INTERVAL_BITS-1:0] : idle_interval;
        end
      end
      default: step_interval = current_interval;
    endcase
    quiet_time_next = activity ? '0 : quiet_acc;
    current_interval_next = step_interval;
    if (fixed_mode) begin
      beat_interval = OUT_BITS'(burst_interval);
      beat_mode     = mode_state;
    end else begin
      beat_interval = OUT_BITS'(step_interval);
      beat_mode     = mode_state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state       <= MODE_IDLE;
      current_interval <= RST_IDLE_INTERVAL;
      quiet_time       <= '0;
    end else if (cfg_we) begin
      mode_state       <= MODE_IDLE;
      current_interval <= fixed_mode_next ? burst_interval_next : idle_interval_next;
      quiet_time       <= '0;
    end else if (in_fire && !fixed_mode) begin
      mode_state       <= mode_state_next;
      current_interval <= current_interval_next;
      quiet_time       <= quiet_time_next;
    end
  end

  // output register and skid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (out_fire) skid_valid <= 1'b0;
    end else if (in_fire) begin
      if (!out_valid || out_fire) out_valid <= 1'b1;
      else                        skid_valid <= 1'b1;
    end else if (out_fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (out_fire) begin
        res_interval <= skid_interval;
        res_mode     <= skid_mode;
      end
    end else if (in_fire) begin
      if (!out_valid || out_fire) begin
        res_interval <= beat_interval;
        res_mode     <= beat_mode;
      end else begin
        skid_interval <= beat_interval;
        skid_mode     <= beat_mode;
      end
    end
  end

  assign interval_us = res_interval;
  assign poll_mode   = res_mode;

  a_stall_needs_beat: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid) else $error("stall raised with empty output register");

  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> out_valid) else $error("accepted tick produced no beat");

  a_fixed_holds: assert property (@(posedge clk) disable iff (rst)
    (in_fire && fixed_mode && !cfg_we) |=> $stable(mode_state) && $stable(quiet_time))
    else $error("state moved in fixed mode");

  a_burst_floor: assert property (@(posedge clk) disable iff (rst)
    (mode_state == MODE_BURST) |-> (current_interval == burst_interval))
    else $error("burst mode off the floor interval");

endmodule
